[rtl/heading_align_controller_top_macros.svh]
// Assertion macros for the heading align controller.
`ifndef HEADING_ALIGN_CONTROLLER_TOP_MACROS_SVH
`define HEADING_ALIGN_CONTROLLER_TOP_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define HAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that one condition implies another in the same cycle.
`define HAC_ASSERT_IMPL(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

`endif

[rtl/hac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hac_pkg;

	localparam int unsigned FULL_TURN = 46080;
	localparam int unsigned HALF_TURN = 23040;

	// Configuration register indexes.
	localparam logic [2:0] REG_TARGET_RADIUS = 3'd0;
	localparam logic [2:0] REG_SLOW_RADIUS   = 3'd1;
	localparam logic [2:0] REG_MAX_ROTATION  = 3'd2;
	localparam logic [2:0] REG_MAX_ACCEL     = 3'd3;
	localparam logic [2:0] REG_TIME_TO_TGT   = 3'd4;

	localparam logic [14:0] RST_TARGET_RADIUS = 15'd128;
	localparam logic [14:0] RST_SLOW_RADIUS   = 15'd1280;
	localparam logic [16:0] RST_MAX_ROTATION  = 17'd11520;
	localparam logic [15:0] RST_MAX_ACCEL     = 16'd11520;
	localparam logic [15:0] RST_TIME_TO_TGT   = 16'd26;

	// Speed divider: product of max rotation and error over the slow radius.
	localparam int unsigned DIV1_QW = 17;
	localparam int unsigned DIV1_DW = 15;
	// Acceleration divider: speed difference times 256 over time to target.
	localparam int unsigned DIV2_QW = 26;
	localparam int unsigned DIV2_DW = 16;

	typedef struct packed {
		logic               aligned;
		logic               neg;
		logic               zero;
		logic               big;
		logic signed [17:0] vel;
	} speed_side_t;

	typedef struct packed {
		logic aligned;
		logic neg;
		logic zero;
	} accel_side_t;

endpackage
`default_nettype wire

[rtl/hac_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
module hac_divider import hac_pkg::*; #(
	parameter int unsigned QW = DIV1_QW,
	parameter int unsigned DW = DIV1_DW,
	parameter int unsigned SW = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [QW+DW-1:0]  dividend,
	input  wire logic [DW-1:0]     divisor,
	input  wire logic [SW-1:0]     side_in,
	output logic                   out_valid,
	output logic [QW-1:0]          quotient,
	output logic [SW-1:0]          side_out
);

	// Entry 0 is the input; entry i+1 is the register after stage i.
	// Each stage resolves one quotient bit, most significant first.
	logic [DW-1:0] rem_sn  [QW+1];
	logic [QW-1:0] q_sn    [QW+1];
	logic [SW-1:0] side_sn [QW+1];
	logic          v_sn    [QW+1];

	assign rem_sn[0]  = dividend[QW+DW-1:QW];
	assign q_sn[0]    = dividend[QW-1:0];
	assign side_sn[0] = side_in;
	assign v_sn[0]    = in_valid;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW+1:0] trial;
		logic          ge;

		always_comb begin
			trial = {1'b0, rem_sn[i], q_sn[i][QW-1]} - {2'b00, divisor};
			ge    = ~trial[DW+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i+1] <= 1'b0;
			end else if (en) begin
				v_sn[i+1] <= v_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[i+1]  <= ge ? trial[DW-1:0] : {rem_sn[i][DW-2:0], q_sn[i][QW-1]};
				q_sn[i+1]    <= {q_sn[i][QW-2:0], ge};
				side_sn[i+1] <= side_sn[i];
			end
		end
	end

	assign out_valid = v_sn[QW];
	assign quotient  = q_sn[QW];
	assign side_out  = side_sn[QW];

endmodule
`default_nettype wire

[rtl/heading_align_controller_top.sv]
// Heading align controller: the angular part of an align steering behaviour.
// Input channel (in_valid / in_ready) takes one request per cycle carrying
// target heading, current heading and angular velocity. Output channel
// (out_valid / out_ready) returns one result per request, in order: the
// aligned flag and the clamped angular acceleration.
// From acceptance to out_valid a request passes through wrap, compare and
// multiply, a 17-stage radix-2 divider for the wanted speed, the speed
// difference, a 26-stage radix-2 divider for the acceleration, then the clamp
// into the output register. Throughput is one request per cycle; the two
// dividers, one quotient bit per stage, set the depth.
// When the receiver stalls, the whole pipeline holds and in_ready falls until
// the output register drains; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults. The
// configuration port (cfg_we, cfg_index, cfg_wdata) writes at once and is
// to be used only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "heading_align_controller_top_macros.svh"
module heading_align_controller_top import hac_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [16:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [16:0] target_heading,
	input  wire logic signed [16:0] current_heading,
	input  wire logic signed [17:0] angular_velocity,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    aligned,
	output logic signed [16:0]      angular_accel
);

	logic [14:0] target_radius_q;
	logic [14:0] slow_radius_q;
	logic [16:0] max_rotation_q;
	logic [15:0] max_accel_q;
	logic [15:0] time_to_tgt_q;

	// One enable moves every stage; it drops only when the output register is
	// full and the receiver is not taking it.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_radius_q <= RST_TARGET_RADIUS;
			slow_radius_q   <= RST_SLOW_RADIUS;
			max_rotation_q  <= RST_MAX_ROTATION;
			max_accel_q     <= RST_MAX_ACCEL;
			time_to_tgt_q   <= RST_TIME_TO_TGT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_RADIUS: target_radius_q <= cfg_wdata[14:0];
				REG_SLOW_RADIUS:   slow_radius_q   <= cfg_wdata[14:0];
				REG_MAX_ROTATION:  max_rotation_q  <= cfg_wdata;
				REG_MAX_ACCEL:     max_accel_q     <= cfg_wdata[15:0];
				REG_TIME_TO_TGT:   time_to_tgt_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Stage 1: heading error, reduced by a truncating remainder modulo a full
	// turn and then wrapped into plus or minus half a turn. The whole-turn
	// offset is picked from compares of the raw difference against fixed
	// thresholds, so only one addition follows the subtraction. A difference
	// that lands exactly on half a turn keeps the sign of the raw difference.
	logic signed [18:0] head_diff;
	logic signed [18:0] wrap_ofs;
	logic signed [18:0] err;
	logic        [18:0] err_abs;
	logic               v_s1;
	logic        [14:0] mag_s1;
	logic               neg_s1;
	logic               zero_s1;
	logic signed [17:0] vel_s1;

	always_comb begin
		head_diff = 19'(signed'({{2{target_heading[16]}}, target_heading}))
			- 19'(signed'({{2{current_heading[16]}}, current_heading}));
		if (head_diff > 19'sd115200) begin
			wrap_ofs = -19'sd138240;
		end else if (head_diff > 19'sd69120) begin
			wrap_ofs = -19'sd92160;
		end else if (head_diff > 19'sd23040) begin
			wrap_ofs = -19'sd46080;
		end else if (head_diff >= -19'sd23040) begin
			wrap_ofs = 19'sd0;
		end else if (head_diff >= -19'sd69120) begin
			wrap_ofs = 19'sd46080;
		end else if (head_diff >= -19'sd115200) begin
			wrap_ofs = 19'sd92160;
		end else begin
			wrap_ofs = 19'sd138240;
		end
		err     = head_diff + wrap_ofs;
		err_abs = err[18] ? 19'(-err) : 19'(err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= err_abs[14:0];
			neg_s1  <= err[18];
			zero_s1 <= (err == 19'sd0);
			vel_s1  <= angular_velocity;
		end
	end

	// Stage 2: aligned test, slow-radius test and the speed product.
	logic              v_s2;
	logic       [31:0] prod_s2;
	speed_side_t       side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2         <= 32'(max_rotation_q) * 32'(mag_s1);
			side_s2.aligned <= mag_s1 < target_radius_q;
			side_s2.neg     <= neg_s1;
			side_s2.zero    <= zero_s1;
			side_s2.big     <= (slow_radius_q == 15'd0) || (mag_s1 > slow_radius_q);
			side_s2.vel     <= vel_s1;
		end
	end

	// Wanted speed magnitude inside the slow radius.
	logic                v_d1;
	logic [DIV1_QW-1:0]  q_d1;
	logic [$bits(speed_side_t)-1:0] side_d1_raw;
	speed_side_t         side_d1;

	hac_divider #(
		.QW(DIV1_QW),
		.DW(DIV1_DW),
		.SW($bits(speed_side_t))
	) u_speed_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.dividend (prod_s2),
		.divisor  (slow_radius_q),
		.side_in  (side_s2),
		.out_valid(v_d1),
		.quotient (q_d1),
		.side_out (side_d1_raw)
	);

	assign side_d1 = speed_side_t'(side_d1_raw);

	// Stage 3: signed wanted speed less the present velocity.
	logic signed [18:0] want;
	logic signed [18:0] diff;
	logic               v_s3;
	logic        [17:0] dmag_s3;
	accel_side_t        side_s3;

	always_comb begin
		want = signed'({2'b00, (side_d1.big ? max_rotation_q : q_d1)});
		if (side_d1.zero) begin
			want = 19'sd0;
		end else if (side_d1.neg) begin
			want = -want;
		end
		diff = want - 19'(side_d1.vel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s3         <= diff[18] ? 18'(-diff) : diff[17:0];
			side_s3.aligned <= side_d1.aligned;
			side_s3.neg     <= diff[18];
			side_s3.zero    <= (diff == 19'sd0);
		end
	end

	// Acceleration magnitude: difference times 256 over time to target. A zero
	// divisor yields an all-ones quotient, which the clamp turns into the limit.
	logic                v_d2;
	logic [DIV2_QW-1:0]  q_d2;
	logic [$bits(accel_side_t)-1:0] side_d2_raw;
	accel_side_t         side_d2;

	hac_divider #(
		.QW(DIV2_QW),
		.DW(DIV2_DW),
		.SW($bits(accel_side_t))
	) u_accel_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.dividend ({16'd0, dmag_s3, 8'd0}),
		.divisor  (time_to_tgt_q),
		.side_in  (side_s3),
		.out_valid(v_d2),
		.quotient (q_d2),
		.side_out (side_d2_raw)
	);

	assign side_d2 = accel_side_t'(side_d2_raw);

	// Output register: clamp, sign and the aligned override.
	logic        [15:0] clamp_mag;
	logic signed [16:0] acc;

	always_comb begin
		clamp_mag = (q_d2 > {10'd0, max_accel_q}) ? max_accel_q : q_d2[15:0];
		if (side_d2.aligned || side_d2.zero) begin
			acc = 17'sd0;
		end else if (side_d2.neg) begin
			acc = -signed'({1'b0, clamp_mag});
		end else begin
			acc = signed'({1'b0, clamp_mag});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aligned       <= side_d2.aligned;
			angular_accel <= acc;
		end
	end

	// An aligned result never asks for any acceleration.
	`HAC_ASSERT_IMPL(a_aligned_zero, out_valid && aligned, angular_accel == 17'sd0, "aligned with accel")
	// A non-negative acceleration never exceeds the configured limit.
	`HAC_ASSERT_IMPL(a_clamp, out_valid && !angular_accel[16], angular_accel[15:0] <= max_accel_q, "clamp exceeded")
	// The pipeline only stops while a finished result is held back.
	`HAC_ASSERT(a_stall, (!in_ready) |-> (out_valid && !out_ready), "stall without backpressure")

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// Checks the heading align controller against a behavioural model of its own.
// Each accepted request pushes its expected aligned flag and acceleration onto
// a queue; a monitor pops the oldest entry on every accepted result and
// compares field by field. Directed tests cover wrap edges, radii and clamp
// extremes, then random requests run under several register settings with
// bursty sending and a stalling receiver.
module testbench;
	import hac_pkg::*;

	// The settle wait is taken with margin over the pipeline latency.
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 400000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [16:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic signed [16:0] target_heading;
	logic signed [16:0] current_heading;
	logic signed [17:0] angular_velocity;
	logic               out_valid;
	logic               out_ready;
	logic               aligned;
	logic signed [16:0] angular_accel;

	typedef struct packed {
		logic               aligned;
		logic signed [16:0] accel;
	} steer_result_t;

	// Our own copy of the configuration registers.
	logic [14:0] m_target_radius;
	logic [14:0] m_slow_radius;
	logic [16:0] m_max_rotation;
	logic [15:0] m_max_accel;
	logic [15:0] m_time_to_tgt;

	steer_result_t pending_results[$];
	int            fail_count;
	int            cycle_count;
	int            stall_mode;
	int            burst_left;

	heading_align_controller_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.target_heading   (target_heading),
		.current_heading  (current_heading),
		.angular_velocity (angular_velocity),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.aligned          (aligned),
		.angular_accel    (angular_accel)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Works out the steering result for one heading sample. The error is
	// wrapped into the half-turn range, the wanted speed follows from the
	// radii, and the speed difference over the time to target is clamped.
	function automatic steer_result_t predict_steering(logic signed [16:0] tgt,
			logic signed [16:0] cur, logic signed [17:0] vel);
		longint        err;
		longint        mag;
		longint        want;
		longint        diff;
		longint        acc;
		longint        lim;
		steer_result_t res;
		err = (longint'(tgt) - longint'(cur)) % longint'(FULL_TURN);
		if (err > longint'(HALF_TURN))
			err -= longint'(FULL_TURN);
		else if (err < -longint'(HALF_TURN))
			err += longint'(FULL_TURN);
		mag = (err < 0) ? -err : err;
		res = '0;
		if (mag < longint'(m_target_radius)) begin
			res.aligned = 1'b1;
			return res;
		end
		if (m_slow_radius == 0 || mag > longint'(m_slow_radius))
			want = longint'(m_max_rotation);
		else
			want = (longint'(m_max_rotation) * mag) / longint'(m_slow_radius);
		if (err < 0)
			want = -want;
		else if (err == 0)
			want = 0;
		diff = want - longint'(vel);
		lim = longint'(m_max_accel);
		if (m_time_to_tgt == 0)
			acc = (diff > 0) ? lim : ((diff < 0) ? -lim : 0);
		else
			acc = (diff * 256) / longint'(m_time_to_tgt);
		if (acc > lim)
			acc = lim;
		else if (acc < -lim)
			acc = -lim;
		res.accel = acc[16:0];
		return res;
	endfunction

	task automatic write_register(input logic [2:0] idx, input logic [16:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TARGET_RADIUS: m_target_radius = value[14:0];
			REG_SLOW_RADIUS:   m_slow_radius   = value[14:0];
			REG_MAX_ROTATION:  m_max_rotation  = value;
			REG_MAX_ACCEL:     m_max_accel     = value[15:0];
			REG_TIME_TO_TGT:   m_time_to_tgt   = value[15:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [14:0] tr, input logic [14:0] sr,
			input logic [16:0] mr, input logic [15:0] ma, input logic [15:0] tt);
		write_register(REG_TARGET_RADIUS, 17'(tr));
		write_register(REG_SLOW_RADIUS, 17'(sr));
		write_register(REG_MAX_ROTATION, mr);
		write_register(REG_MAX_ACCEL, 17'(ma));
		write_register(REG_TIME_TO_TGT, 17'(tt));
	endtask

	// Sends one request, holding it until accepted. Between bursts the
	// sender drops valid for a random gap. Called just after a rising edge.
	task automatic send_request(input logic signed [16:0] tgt,
			input logic signed [16:0] cur, input logic signed [17:0] vel);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid         <= 1'b1;
		target_heading   <= tgt;
		current_heading  <= cur;
		angular_velocity <= vel;
		pending_results.push_back(predict_steering(tgt, cur, vel));
		do
			@(posedge clk);
		while (!in_ready);
		// The caller either drives the next request or lowers valid here.
	endtask

	task automatic idle_sender();
		in_valid <= 1'b0;
	endtask

	// Waits until every expected result has come, then lets the pipe settle.
	task automatic drain_results();
		idle_sender();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [16:0] rand_heading();
		if ($urandom_range(0, 9) == 0)
			return 17'($urandom);
		return 17'($signed($urandom_range(0, 92158)) - 46079);
	endfunction

	function automatic logic signed [17:0] rand_velocity();
		if ($urandom_range(0, 9) == 0)
			return 18'($urandom);
		return 18'($signed($urandom_range(0, 262142)) - 131071);
	endfunction

	task automatic test_wrap_edges();
		send_request(17'sd23040, 17'sd0, 18'sd0);
		send_request(-17'sd23040, 17'sd0, 18'sd0);
		send_request(17'sd23041, 17'sd0, 18'sd0);
		send_request(-17'sd23041, 17'sd0, 18'sd0);
		send_request(17'sd46079, -17'sd46079, 18'sd0);
		send_request(-17'sd46079, 17'sd46079, 18'sd131071);
		send_request(-17'sd65536, 17'sd65535, -18'sd131072);
		send_request(17'sd46080, 17'sd0, 18'sd0);
	endtask

	task automatic test_radii_and_clamp();
		send_request(17'sd0, 17'sd0, 18'sd0);
		send_request(17'sd127, 17'sd0, 18'sd0);
		send_request(17'sd128, 17'sd0, 18'sd0);
		send_request(-17'sd128, 17'sd0, 18'sd131071);
		send_request(17'sd1280, 17'sd0, 18'sd0);
		send_request(17'sd1281, 17'sd0, -18'sd131071);
		send_request(17'sd700, 17'sd0, 18'sd5);
		send_request(-17'sd700, 17'sd0, -18'sd5);
		send_request(17'sd5000, 17'sd0, 18'sd11520);
		drain_results();
		// Zero radii and zero time to target, beyond the stated ranges.
		load_settings(15'd0, 15'd0, 17'd131071, 16'd65535, 16'd0);
		send_request(17'sd0, 17'sd0, 18'sd0);
		send_request(17'sd0, 17'sd0, 18'sd7);
		send_request(17'sd0, 17'sd0, -18'sd7);
		send_request(17'sd1, 17'sd0, 18'sd0);
		drain_results();
		load_settings(15'd23040, 15'd23040, 17'd0, 16'd0, 16'd65535);
		send_request(17'sd23040, 17'sd0, 18'sd100);
		send_request(17'sd22000, 17'sd0, 18'sd100);
		drain_results();
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_request(rand_heading(), rand_heading(), rand_velocity());
		drain_results();
	endtask

	// Receiver stall pattern: mode changes every so often between always
	// ready, a sparse stall and a heavy stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Result checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result aligned=%0b accel=%0d", $time,
					aligned, angular_accel);
				fail_count++;
			end else begin
				steer_result_t exp_res;
				exp_res = pending_results.pop_front();
				if (aligned !== exp_res.aligned) begin
					$display("%0t: aligned mismatch expected %0b actual %0b", $time,
						exp_res.aligned, aligned);
					fail_count++;
				end
				if (angular_accel !== exp_res.accel) begin
					$display("%0t: angular_accel mismatch expected %0d actual %0d",
						$time, exp_res.accel, angular_accel);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		fail_count       = 0;
		cycle_count      = 0;
		burst_left       = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_TARGET_RADIUS;
		cfg_wdata        = '0;
		in_valid         = 1'b0;
		target_heading   = '0;
		current_heading  = '0;
		angular_velocity = '0;
		m_target_radius  = RST_TARGET_RADIUS;
		m_slow_radius    = RST_SLOW_RADIUS;
		m_max_rotation   = RST_MAX_ROTATION;
		m_max_accel      = RST_MAX_ACCEL;
		m_time_to_tgt    = RST_TIME_TO_TGT;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wrap_edges();
		// The sender holds off here until every result is home.
		drain_results();
		test_radii_and_clamp();

		load_settings(RST_TARGET_RADIUS, RST_SLOW_RADIUS, RST_MAX_ROTATION,
			RST_MAX_ACCEL, RST_TIME_TO_TGT);
		test_random(150);
		load_settings(15'd1, 15'd23040, 17'd131071, 16'd65535, 16'd1);
		test_random(100);
		load_settings(15'd23040, 15'd1, 17'd0, 16'd0, 16'd65535);
		test_random(50);
		load_settings(15'($urandom_range(1, 3000)), 15'($urandom_range(1, 23040)),
			17'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
		test_random(150);
		load_settings(15'd64, 15'd4000, 17'd90000, 16'd30000, 16'd3);
		test_random(100);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
